FILE: design/ccrc_pkg.sv
// Shared types and constants for the configurable CRC generator/checker.
`default_nettype none

package ccrc_pkg;

	localparam int MAX_DEGREE = 32;
	localparam int REM_W      = 32;
	localparam int DEG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TAPS      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CHECKMODE = CFG_IDX_W'(2);

	localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(16);
	localparam logic [REM_W-1:0] TAPS_RESET   = REM_W'(32'h0000_1021);

	typedef struct packed {
		logic data_bit;
		logic last_bit;
	} item_t;

	typedef struct packed {
		logic [DEG_W-1:0] degree;
		logic [REM_W-1:0] generator_taps;
		logic             check_mode;
	} cfg_t;

endpackage

`default_nettype wire

FILE: design/ccrc_front.sv
// Input stage: takes items from the bit stream and forms queue entries.
`default_nettype none

module ccrc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            data_bit,
	input  wire logic            last_bit,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output ccrc_pkg::item_t      push_item
);

	logic            valid_s1;
	ccrc_pkg::item_t item_s1;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.data_bit <= data_bit;
			item_s1.last_bit <= last_bit;
		end
	end

endmodule

`default_nettype wire

FILE: design/ccrc_queue.sv
// Short FIFO of items between the input stage and the division engine.
`default_nettype none

module ccrc_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire ccrc_pkg::item_t      push_item,
	output logic                      pop_valid,
	input  wire logic                 pop_ready,
	output ccrc_pkg::item_t           pop_item
);

	ccrc_pkg::item_t                   slots_q [ccrc_pkg::QUEUE_DEPTH];
	logic [ccrc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [ccrc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [ccrc_pkg::QCNT_W-1:0]       count_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = (count_q != ccrc_pkg::QCNT_W'(ccrc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [ccrc_pkg::QPTR_W-1:0] next_ptr(
		input logic [ccrc_pkg::QPTR_W-1:0] p);
		if (p == ccrc_pkg::QPTR_W'(ccrc_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + ccrc_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + ccrc_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - ccrc_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: design/ccrc_back.sv
// Division engine: one LFSR step per item, result register on the last bit.
`default_nettype none

module ccrc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ccrc_pkg::cfg_t             cfg,
	input  wire logic                       pop_valid,
	output logic                            pop_ready,
	input  wire ccrc_pkg::item_t            pop_item,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [ccrc_pkg::REM_W-1:0]      remainder,
	output logic                            error_found
);

	logic [ccrc_pkg::REM_W-1:0] rem_q;
	logic [ccrc_pkg::REM_W-1:0] result_q;
	logic                       error_q;
	logic                       out_valid_q;

	logic [ccrc_pkg::DEG_W-1:0] deg_eff;
	logic [ccrc_pkg::DEG_W-1:0] deg_m1;
	logic [ccrc_pkg::REM_W:0]   mask_wide;
	logic [ccrc_pkg::REM_W-1:0] mask;
	logic [ccrc_pkg::REM_W-1:0] taps;
	logic [ccrc_pkg::REM_W-1:0] cur;
	logic [ccrc_pkg::REM_W-1:0] shifted;
	logic [ccrc_pkg::REM_W-1:0] rem_next;
	logic                       top;
	logic                       feedback;
	logic                       out_free;
	logic                       do_pop;

	always_comb begin
		if (cfg.degree == '0) begin
			deg_eff = ccrc_pkg::DEG_W'(1);
		end else if (cfg.degree > ccrc_pkg::DEG_W'(ccrc_pkg::MAX_DEGREE)) begin
			deg_eff = ccrc_pkg::DEG_W'(ccrc_pkg::MAX_DEGREE);
		end else begin
			deg_eff = cfg.degree;
		end
		deg_m1    = deg_eff - ccrc_pkg::DEG_W'(1);
		mask_wide = ((ccrc_pkg::REM_W+1)'(1) << deg_eff) - (ccrc_pkg::REM_W+1)'(1);
		mask      = mask_wide[ccrc_pkg::REM_W-1:0];
		taps      = cfg.generator_taps & mask;
		cur       = rem_q & mask;
		top       = cur[deg_m1[$clog2(ccrc_pkg::REM_W)-1:0]];
		// check mode shifts the bit into the register; generate mode feeds it back
		if (cfg.check_mode) begin
			shifted  = ({cur[ccrc_pkg::REM_W-2:0], 1'b0} | ccrc_pkg::REM_W'(pop_item.data_bit))
			           & mask;
			feedback = top;
		end else begin
			shifted  = {cur[ccrc_pkg::REM_W-2:0], 1'b0} & mask;
			feedback = top ^ pop_item.data_bit;
		end
		rem_next = feedback ? (shifted ^ taps) : shifted;
	end

	assign out_free    = !out_valid_q || out_ready;
	assign pop_ready   = !pop_item.last_bit || out_free;
	assign do_pop      = pop_valid && pop_ready;
	assign out_valid   = out_valid_q;
	assign remainder   = result_q;
	assign error_found = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				rem_q <= pop_item.last_bit ? '0 : rem_next;
			end
			if (out_free) begin
				out_valid_q <= do_pop && pop_item.last_bit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && do_pop && pop_item.last_bit) begin
			result_q <= rem_next;
			error_q  <= cfg.check_mode && (rem_next != '0);
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(result_q) && $stable(error_q))
		else $error("result changed while waiting");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && pop_item.last_bit |=> rem_q == '0)
		else $error("remainder not cleared after last item");

	a_error_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> result_q != '0)
		else $error("error flagged on zero remainder");

	a_last_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && pop_item.last_bit |-> !out_valid_q || out_ready)
		else $error("last item taken with result register occupied");

endmodule

`default_nettype wire

FILE: design/configurable_crc_generate_check.sv
// Top level of the configurable CRC generator/checker.
// One message bit per item, most significant first; an item with last_bit set
// yields one result (remainder, error_found) and clears the running remainder.
// Sustained rate is one item per clock while out_ready takes each result: each
// bit costs a single LFSR step in the division engine. The last item passes the
// input register and the queue; the result register loads, and out_valid rises,
// as the item leaves the queue. A result held by out_ready low stalls only the
// next last item. Registers: 0 degree (1..32; 0 acts as 1, larger values as 32),
// 1 generator taps below the leading one, 2 check mode. Write them only while no
// message is in flight.
`default_nettype none

module configurable_crc_generate_check (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              data_bit,
	input  wire logic                              last_bit,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [ccrc_pkg::REM_W-1:0]             remainder,
	output logic                                   error_found,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ccrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ccrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ccrc_pkg::cfg_t  cfg_q;
	ccrc_pkg::item_t push_item;
	ccrc_pkg::item_t pop_item;
	logic            push_valid;
	logic            push_ready;
	logic            pop_valid;
	logic            pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree         <= ccrc_pkg::DEGREE_RESET;
			cfg_q.generator_taps <= ccrc_pkg::TAPS_RESET;
			cfg_q.check_mode     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ccrc_pkg::REG_DEGREE:    cfg_q.degree <= cfg_data[ccrc_pkg::DEG_W-1:0];
				ccrc_pkg::REG_TAPS:      cfg_q.generator_taps <= cfg_data[ccrc_pkg::REM_W-1:0];
				ccrc_pkg::REG_CHECKMODE: cfg_q.check_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ccrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_bit   (data_bit),
		.last_bit   (last_bit),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	ccrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	ccrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.remainder   (remainder),
		.error_found (error_found)
	);

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the configurable CRC generator/checker.
`timescale 1ns / 100ps

module testbench;

	localparam int RAND_ITEMS     = 1900;
	localparam int LATENCY        = 3;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int DIR_ROWS       = 31;
	localparam int RX_HOLD_CYCLES = 400;
	localparam logic [ccrc_pkg::CFG_IDX_W-1:0] REG_UNUSED = ccrc_pkg::CFG_IDX_W'(3);

	typedef struct packed {
		logic [ccrc_pkg::REM_W-1:0] rem;
		logic                       err;
	} crc_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		logic [ccrc_pkg::CFG_IDX_W-1:0]  idx;
		logic [ccrc_pkg::CFG_DATA_W-1:0] val;
		logic                            db;
		logic                            lb;
		logic                            typed;
		logic [ccrc_pkg::REM_W-1:0]      rem;
		logic                            err;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            data_bit = 1'b0;
	logic                            last_bit = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [ccrc_pkg::REM_W-1:0]      remainder;
	logic                            error_found;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ccrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ccrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state, mirrors the block's registers
	logic [ccrc_pkg::DEG_W-1:0]      cfg_degree = ccrc_pkg::DEGREE_RESET;
	logic [ccrc_pkg::REM_W-1:0]      cfg_taps = ccrc_pkg::TAPS_RESET;
	logic                            cfg_check = 1'b0;
	logic [ccrc_pkg::REM_W-1:0]      running_rem = '0;
	crc_result_t                     crc_expected[$];

	// hand-typed result for the item currently offered
	logic                            typed_on = 1'b0;
	crc_result_t                     typed_exp = '0;

	int mismatches = 0;
	int bits_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;
	int hold_requests = 0;
	int hold_served = 0;

	dir_row_t dir_table [DIR_ROWS];

	configurable_crc_generate_check uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_bit(data_bit),
		.last_bit(last_bit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.remainder(remainder),
		.error_found(error_found),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("configurable_crc_generate_check regression: fail");
		$finish;
	end

	function automatic int unsigned eff_deg(input logic [ccrc_pkg::DEG_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > ccrc_pkg::MAX_DEGREE)
			return ccrc_pkg::MAX_DEGREE;
		return int'(d);
	endfunction

	// one division step of the running remainder
	function automatic logic [ccrc_pkg::REM_W-1:0] crc_shift(
			input logic [ccrc_pkg::REM_W-1:0] r, input logic b, input logic chk,
			input logic [ccrc_pkg::DEG_W-1:0] d, input logic [ccrc_pkg::REM_W-1:0] taps);
		int unsigned n;
		logic [ccrc_pkg::REM_W-1:0] m;
		logic [ccrc_pkg::REM_W-1:0] x;
		logic top;
		n = eff_deg(d);
		m = (n >= ccrc_pkg::REM_W) ? '1 :
			((ccrc_pkg::REM_W'(1) << n) - ccrc_pkg::REM_W'(1));
		x = r & m;
		top = x[n-1];
		if (chk) begin
			x = ((x << 1) | ccrc_pkg::REM_W'(b)) & m;
			if (top)
				x ^= taps & m;
		end else begin
			x = (x << 1) & m;
			if (top ^ b)
				x ^= taps & m;
		end
		return x;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : crc_tracker
		crc_result_t got;
		crc_result_t want;
		logic [ccrc_pkg::REM_W-1:0] nxt;
		if (arst_n) begin
			got.rem = remainder;
			got.err = error_found;
			if (out_valid && out_ready) begin
				if (crc_expected.size() == 0) begin
					note_mismatch($sformatf("unexpected result rem=%08h err=%0b",
						got.rem, got.err));
				end else begin
					want = crc_expected.pop_front();
					if (got.rem !== want.rem)
						note_mismatch($sformatf("remainder %08h, expected %08h",
							got.rem, want.rem));
					if (got.err !== want.err)
						note_mismatch($sformatf("error_found %0b, expected %0b",
							got.err, want.err));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ccrc_pkg::REG_DEGREE: cfg_degree = cfg_data[ccrc_pkg::DEG_W-1:0];
					ccrc_pkg::REG_TAPS: cfg_taps = cfg_data[ccrc_pkg::REM_W-1:0];
					ccrc_pkg::REG_CHECKMODE: cfg_check = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				nxt = crc_shift(running_rem, data_bit, cfg_check, cfg_degree, cfg_taps);
				if (last_bit) begin
					want.rem = nxt;
					want.err = cfg_check && (nxt != 0);
					crc_expected.push_back(typed_on ? typed_exp : want);
					running_rem = '0;
				end else begin
					running_rem = nxt;
				end
			end
		end
	end

	// result side: random stalls, plus a forced hold-off on each new hold request
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			rx_hold = RX_HOLD_CYCLES;
		end
		if (rx_hold > 0) begin
			out_ready = 1'b0;
			rx_hold--;
		end else begin
			out_ready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_item(input logic db, input logic lb, input logic has_typed,
			input crc_result_t typed);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_bit = db;
		last_bit = lb;
		typed_on = has_typed;
		typed_exp = typed;
		do @(posedge clk); while (!in_ready);
		bits_sent++;
	endtask

	// stop sending, let every pending result drain, then let the pipeline empty
	task automatic settle();
		int guard;
		@(negedge clk);
		in_valid = 1'b0;
		guard = 0;
		while (crc_expected.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		while (crc_expected.size() != 0) begin
			crc_result_t lost;
			lost = crc_expected.pop_front();
			note_mismatch($sformatf("result never came: rem=%08h err=%0b",
				lost.rem, lost.err));
		end
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic program_reg(input logic [ccrc_pkg::CFG_IDX_W-1:0] idx,
			input logic [ccrc_pkg::CFG_DATA_W-1:0] val);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_config();
		logic [ccrc_pkg::CFG_DATA_W-1:0] deg_word;
		logic [ccrc_pkg::CFG_DATA_W-1:0] taps_word;
		deg_word = $urandom;
		case ($urandom_range(7))
			0: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(0);
			1: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(1);
			2: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(2);
			3: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(31);
			4: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(32);
			5: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(33);
			6: deg_word[ccrc_pkg::DEG_W-1:0] = ccrc_pkg::DEG_W'(63);
			default: ;
		endcase
		case ($urandom_range(7))
			0: taps_word = '0;
			1: taps_word = '1;
			default: taps_word = $urandom;
		endcase
		program_reg(ccrc_pkg::REG_DEGREE, deg_word);
		program_reg(ccrc_pkg::REG_TAPS, taps_word);
		program_reg(ccrc_pkg::REG_CHECKMODE, $urandom);
	endtask

	// random message; in check mode mostly a proper codeword, sometimes with one bit hit
	task automatic send_message();
		logic bits[$];
		logic [ccrc_pkg::REM_W-1:0] crc;
		int len;
		int pick;
		int n;
		int p;
		pick = $urandom_range(99);
		if (pick < 80)
			len = $urandom_range(24, 1);
		else if (pick < 95)
			len = $urandom_range(64, 25);
		else
			len = $urandom_range(200, 65);
		for (int i = 0; i < len; i++)
			bits.push_back(1'($urandom_range(1)));
		if (cfg_check && $urandom_range(99) < 60) begin
			n = eff_deg(cfg_degree);
			crc = '0;
			foreach (bits[i])
				crc = crc_shift(crc, bits[i], 1'b0, cfg_degree, cfg_taps);
			for (int k = n - 1; k >= 0; k--)
				bits.push_back(crc[k]);
			if ($urandom_range(99) < 30) begin
				p = $urandom_range(bits.size() - 1);
				bits[p] = ~bits[p];
			end
		end
		foreach (bits[i])
			send_item(bits[i], i == bits.size() - 1, 1'b0, '0);
	endtask

	initial begin
		dir_table = '{
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_1021, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b1, 1'b1, 32'h0000_2042, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_CHECKMODE, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b1},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
			// degree zero acts as one; taps above it are dropped
			'{ROW_CFG, ccrc_pkg::REG_DEGREE, 32'hFFFF_FFC0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_TAPS, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b1},
			'{ROW_CFG, REG_UNUSED, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b1},
			// degree beyond the maximum saturates
			'{ROW_CFG, ccrc_pkg::REG_DEGREE, 32'h0000_003F, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_TAPS, 32'h04C1_1DB7, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_CHECKMODE, 32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h04C1_1DB7, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_DEGREE, 32'h0000_0020, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_TAPS, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_CFG, ccrc_pkg::REG_CHECKMODE, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
			'{ROW_ITEM, ccrc_pkg::REG_DEGREE, 32'h0, 1'b1, 1'b1, 1'b1, 32'h0000_0005, 1'b1}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 7;
		rx_idle_pct = 59;
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CFG)
				program_reg(dir_table[i].idx, dir_table[i].val);
			else
				send_item(dir_table[i].db, dir_table[i].lb, dir_table[i].typed,
					'{rem: dir_table[i].rem, err: dir_table[i].err});
		end

		bits_sent = 0;
		for (int r = 0; r < 3; r++) begin
			tx_idle_pct = (r == 0) ? 7 : (r == 1) ? 59 : 0;
			rx_idle_pct = (r == 0) ? 59 : (r == 1) ? 7 : 0;
			random_config();
			// sender waits for every outstanding result before going on
			send_message();
			settle();
			if (r == 2) begin
				// long receiver hold-off with a dense stream of one-bit messages
				hold_requests++;
				repeat (120)
					send_item(1'($urandom_range(1)), 1'b1, 1'b0, '0);
			end
			while (bits_sent < (r + 1) * RAND_ITEMS / 3) begin
				random_config();
				repeat ($urandom_range(10, 3))
					send_message();
			end
		end

		settle();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("configurable_crc_generate_check regression: pass");
		else
			$display("configurable_crc_generate_check regression: fail");
		$finish;
	end

endmodule
